[hdl/sm3_hash_engine_core_defines.svh]
// Assertion macros for the SM3 hash engine.
`ifndef SM3_HASH_ENGINE_CORE_DEFINES_SVH
`define SM3_HASH_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTH
`define SM3_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");
`define SM3_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");
`else
`define SM3_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SM3_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/sm3_pkg.sv]
// Shared types, constants and functions of the SM3 hash engine.
package sm3_pkg;
    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [255:0] SM3_IV = {
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_START = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic [3:0]  addr;
        logic [31:0] data;
    } t_dp_cmd;

    typedef struct packed {
        logic        done;
    } t_dp_status;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction
endpackage

[hdl/sm3_hash_engine_core.sv]
// Top level of the SM3 hash engine: controller plus compression datapath.
// Message words are taken one per cycle while input is not stalled; every 16th word starts a
// 64-round compression at one round per cycle, and input stays stalled until it ends. The final
// word adds one padding load per remaining block position (up to 16 per block), one or two
// compressions with input stalled, and eight digest transfers; then the engine starts a new message.
module sm3_hash_engine_core
    import sm3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic        o_digest_last
);
    t_dp_cmd      cmd;
    t_dp_status   status;
    logic [255:0] chain;

    sm3_control u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_message_word, .i_valid_bytes,
        .i_last_word, .o_valid, .i_stall, .o_digest_word, .o_digest_last,
        .o_cmd(cmd), .i_status(status), .i_chain(chain));

    sm3_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status), .o_chain(chain));
endmodule

[hdl/sm3_datapath.sv]
// Compression datapath: block buffer, 16-word expansion window, round logic, chain value.
module sm3_datapath
    import sm3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output logic [255:0] o_chain
);
    logic [31:0]  r_buf [16];
    logic [31:0]  r_w   [16];
    logic [255:0] r_v;
    logic [255:0] r_abc;
    logic [5:0]   r_j;
    logic         r_busy;
    logic [31:0]  a, b, c, d, e, f, g, h, ff, gg, tj, ss1, ss2, tt1, tt2, a12, wn;

    always_comb begin
        {a, b, c, d, e, f, g, h} = r_abc;
        a12 = rotl(a, 5'd12);
        if (r_j < 6'd16) begin
            tj = T_LOW;
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
        end else begin
            tj = T_HIGH;
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
        end
        ss1 = rotl(a12 + e + rotl(tj, r_j[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        tt1 = ff + d + ss2 + (r_w[0] ^ r_w[4]);
        tt2 = gg + h + ss1 + r_w[0];
        wn  = p1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15)) ^ rotl(r_w[3], 5'd7) ^ r_w[10];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_LOAD) begin
            r_buf[i_cmd.addr] <= i_cmd.data;
        end
        if (i_cmd.op == CMD_START) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_buf[i];
            r_w[15] <= i_cmd.data;
            r_abc <= r_v;
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= wn;
            r_abc <= {tt1, a, rotl(b, 5'd9), c, p0(tt2), e, rotl(f, 5'd19), g};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= SM3_IV;
            r_busy <= 1'b0;
            r_j    <= '0;
            o_status.done <= 1'b0;
        end else begin
            o_status.done <= 1'b0;
            if (i_cmd.op == CMD_CLEAR) begin
                r_v <= SM3_IV;
            end
            if (i_cmd.op == CMD_START) begin
                r_busy <= 1'b1;
                r_j    <= '0;
            end else if (r_busy) begin
                r_j <= r_j + 6'd1;
                if (r_j == 6'd63) begin
                    r_busy <= 1'b0;
                    r_v    <= r_v ^ {tt1, a, rotl(b, 5'd9), c, p0(tt2), e,
                                     rotl(f, 5'd19), g};
                    o_status.done <= 1'b1;
                end
            end
        end
    end

    assign o_chain = r_v;
endmodule

[hdl/sm3_control.sv]
// Controller: word intake, padding sequence, compression start, digest output.
module sm3_control
    import sm3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic        o_digest_last,
    output t_dp_cmd     o_cmd,
    input  t_dp_status  i_status,
    input  logic [255:0] i_chain
);
`include "sm3_hash_engine_core_defines.svh"
    typedef enum logic [1:0] {S_IDLE, S_PAD, S_WAIT, S_OUT} t_state;
    t_state      r_state;
    logic [3:0]  r_fill;
    logic [63:0] r_len;
    logic        r_pad;      // message ended, padding not finished
    logic        r_bit80;    // 0x80 word still owed
    logic        r_hi;       // length high word written in this block
    logic        r_final;    // running compression is the last of the message
    logic [255:0] r_dig;
    logic [2:0]  r_idx;
    logic        acc, out_acc;
    logic [2:0]  nb;
    logic [31:0] keep, pw, pad_word;
    logic [63:0] len_n;

    assign acc     = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign nb      = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;

    always_comb begin
        unique case (nb)
            3'd0: keep = 32'h0;
            3'd1: keep = 32'hff000000;
            3'd2: keep = 32'hffff0000;
            3'd3: keep = 32'hffffff00;
            default: keep = 32'hffffffff;
        endcase
        pw = (i_message_word & keep) | ((nb == 3'd4) ? 32'h0 : (32'h80000000 >> {nb, 3'b000}));
        len_n = r_len + (i_last_word ? {58'd0, nb, 3'd0} : 64'd32);
        priority if (r_bit80) pad_word = 32'h80000000;
        else if (r_fill == 4'd14) pad_word = r_len[63:32];
        else if (r_fill == 4'd15 && r_hi) pad_word = r_len[31:0];
        else pad_word = 32'h0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_len   <= '0;
            r_pad   <= 1'b0;
            r_bit80 <= 1'b0;
            r_hi    <= 1'b0;
            r_final <= 1'b0;
            r_idx   <= '0;
            o_valid <= 1'b0;
            o_cmd   <= '0;
        end else begin
            o_cmd.op <= CMD_NONE;
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_len  <= len_n;
                        o_cmd.addr <= r_fill;
                        o_cmd.data <= i_last_word ? pw : i_message_word;
                        o_cmd.op   <= (r_fill == 4'd15) ? CMD_START : CMD_LOAD;
                        r_fill <= r_fill + 4'd1;
                        r_pad  <= i_last_word;
                        r_bit80 <= i_last_word && (nb == 3'd4);
                        if (r_fill == 4'd15) r_state <= S_WAIT;
                        else if (i_last_word) r_state <= S_PAD;
                    end
                end
                S_PAD: begin
                    o_cmd.addr <= r_fill;
                    o_cmd.data <= pad_word;
                    r_bit80 <= 1'b0;
                    r_fill  <= r_fill + 4'd1;
                    if (!r_bit80 && r_fill == 4'd14) r_hi <= 1'b1;
                    if (r_fill == 4'd15) begin
                        o_cmd.op <= CMD_START;
                        r_final  <= r_hi;
                        r_state  <= S_WAIT;
                    end else begin
                        o_cmd.op <= CMD_LOAD;
                    end
                end
                S_WAIT: begin
                    if (i_status.done) begin
                        if (r_final) begin
                            r_state <= S_OUT;
                            o_valid <= 1'b1;
                            r_idx   <= '0;
                            r_final <= 1'b0;
                            r_pad   <= 1'b0;
                            r_hi    <= 1'b0;
                        end else if (r_pad) begin
                            r_state <= S_PAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            o_valid <= 1'b0;
                            o_cmd.op <= CMD_CLEAR;
                            r_len <= '0;
                            r_fill <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT && i_status.done) r_dig <= i_chain;
        else if (r_state == S_OUT && out_acc) r_dig <= r_dig << 32;
    end

    assign o_digest_word = r_dig[255:224];
    assign o_digest_last = (r_idx == 3'd7);

    `SM3_ASSERT_IMP(a_out_only_in_out, i_clk, i_rst_n, o_valid, r_state == S_OUT)
    `SM3_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `SM3_ASSERT_NXT(a_clear_after_last, i_clk, i_rst_n, out_acc && o_digest_last,
        r_state == S_IDLE && r_fill == 4'd0)
endmodule
